>>> rtl/core/slaq_pkg.sv
package slaq_pkg;

    // Port field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;
    localparam int HEAD_W  = 7;
    localparam int WAIT_W  = 3;
    localparam int EV_W    = 3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Line terminators
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EV_W-1:0] EV_STORED   = 3'd1;
    localparam logic [EV_W-1:0] EV_QUEUED   = 3'd2;
    localparam logic [EV_W-1:0] EV_EMPTY    = 3'd3;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd4;
    localparam logic [EV_W-1:0] EV_OVERLONG = 3'd5;
    localparam logic [EV_W-1:0] EV_RELEASED = 3'd6;

endpackage

>>> rtl/core/serial_line_assembler_queue_core.sv
// An accepted item moves the core to S_DONE; its result is registered to the output
// when the output is free, and o_stall holds off new items until then.
// Lines are assembled in place in a spare slot of the store, so committing a line
// is a pointer update and needs no copy.
// Reset (synchronous, active low) clears the pointers, counts and handshake state;
// the line store and slot lengths are not cleared.
module serial_line_assembler_queue_core #(
    parameter int LINE_LEN    = 96,
    parameter int QUEUE_DEPTH = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [slaq_pkg::CMD_W-1:0]    i_command,
    input  logic [slaq_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [slaq_pkg::INDEX_W-1:0]  i_char_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [slaq_pkg::BYTE_W-1:0]   o_read_char,
    output logic [slaq_pkg::HEAD_W-1:0]   o_head_length,
    output logic [slaq_pkg::WAIT_W-1:0]   o_lines_waiting,
    output logic [slaq_pkg::EV_W-1:0]     o_event_code
);

    localparam int LW    = $clog2(LINE_LEN);
    localparam int NSLOT = QUEUE_DEPTH + 1;   // one spare slot holds the line being built
    localparam int SW    = $clog2(NSLOT);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = SW + LW;
    localparam int CMPW  = (LW > slaq_pkg::INDEX_W) ? LW + 1 : slaq_pkg::INDEX_W + 1;

    typedef enum logic {S_IDLE, S_DONE} t_state;

    t_state                       r_state;
    logic [LW-1:0]                r_blen;
    logic [SW-1:0]                r_rd_slot;
    logic [SW-1:0]                r_wr_slot;
    logic [CW-1:0]                r_count;
    logic [slaq_pkg::EV_W-1:0]    r_ev;
    logic                         r_hit;
    logic                         r_out_valid;
    logic [slaq_pkg::BYTE_W-1:0]  r_out_char;
    logic [slaq_pkg::HEAD_W-1:0]  r_out_head;
    logic [slaq_pkg::WAIT_W-1:0]  r_out_wait;
    logic [slaq_pkg::EV_W-1:0]    r_out_ev;

    logic [slaq_pkg::BYTE_W-1:0]  r_mem [NSLOT << LW];
    logic [LW-1:0]                r_slot_len [NSLOT];
    logic [slaq_pkg::BYTE_W-1:0]  r_mem_q;

    logic                         accept;
    logic                         out_free;
    logic                         mem_we;
    logic                         mem_re;
    logic                         len_we;
    logic [AW-1:0]                mem_raddr;
    logic [AW-1:0]                mem_waddr;
    logic                         rd_hit;
    logic [LW-1:0]                n_blen;
    logic [SW-1:0]                n_rd_slot;
    logic [SW-1:0]                n_wr_slot;
    logic [CW-1:0]                n_count;
    logic [slaq_pkg::EV_W-1:0]    n_ev;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(NSLOT - 1)) ? '0 : SW'(s + 1'b1);
    endfunction

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign mem_waddr = {r_wr_slot, r_blen};
    assign mem_raddr = {r_rd_slot, LW'(i_char_index)};
    assign rd_hit    = (r_count != '0)
                    && (CMPW'(i_char_index) < CMPW'(r_slot_len[r_rd_slot]));

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        len_we    = 1'b0;
        n_blen    = r_blen;
        n_rd_slot = r_rd_slot;
        n_wr_slot = r_wr_slot;
        n_count   = r_count;
        n_ev      = slaq_pkg::EV_NONE;
        case (i_command)
            slaq_pkg::CMD_BYTE: begin
                if (i_byte_value inside {slaq_pkg::BYTE_LF, slaq_pkg::BYTE_CR}) begin
                    n_blen = '0;
                    if (r_blen == '0) begin
                        n_ev = slaq_pkg::EV_EMPTY;
                    end else if (r_count < CW'(QUEUE_DEPTH)) begin
                        len_we    = accept;
                        n_wr_slot = next_slot(r_wr_slot);
                        n_count   = CW'(r_count + 1'b1);
                        n_ev      = slaq_pkg::EV_QUEUED;
                    end else begin
                        n_ev = slaq_pkg::EV_FULL;
                    end
                end else if (r_blen < LW'(LINE_LEN - 1)) begin
                    mem_we = accept;
                    n_blen = LW'(r_blen + 1'b1);
                    n_ev   = slaq_pkg::EV_STORED;
                end else begin
                    n_blen = '0;
                    n_ev   = slaq_pkg::EV_OVERLONG;
                end
            end
            slaq_pkg::CMD_READ: begin
                mem_re = accept && rd_hit;
            end
            slaq_pkg::CMD_RELEASE: begin
                if (r_count != '0) begin
                    n_rd_slot = next_slot(r_rd_slot);
                    n_count   = CW'(r_count - 1'b1);
                    n_ev      = slaq_pkg::EV_RELEASED;
                end
            end
            default: begin
            end
        endcase
    end

    // Line store and slot lengths: no reset, only written entries are ever read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_byte_value;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
        if (len_we) begin
            r_slot_len[r_wr_slot] <= r_blen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blen      <= '0;
            r_rd_slot   <= '0;
            r_wr_slot   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_blen    <= n_blen;
                        r_rd_slot <= n_rd_slot;
                        r_wr_slot <= n_wr_slot;
                        r_count   <= n_count;
                        r_ev      <= n_ev;
                        r_hit     <= (i_command == slaq_pkg::CMD_READ) && rd_hit;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= r_hit ? r_mem_q : '0;
                        r_out_head  <= (r_count != '0)
                                     ? slaq_pkg::HEAD_W'(r_slot_len[r_rd_slot]) : '0;
                        r_out_wait  <= slaq_pkg::WAIT_W'(r_count);
                        r_out_ev    <= r_ev;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_char     = r_out_char;
    assign o_head_length   = r_out_head;
    assign o_lines_waiting = r_out_wait;
    assign o_event_code    = r_out_ev;

endmodule

>>> rtl/core/slaq_checker.sv
module slaq_checker #(
    parameter int LINE_LEN    = 96,
    parameter int QUEUE_DEPTH = 6
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [slaq_pkg::BYTE_W-1:0]   o_read_char,
    input logic [slaq_pkg::HEAD_W-1:0]   o_head_length,
    input logic [slaq_pkg::WAIT_W-1:0]   o_lines_waiting,
    input logic [slaq_pkg::EV_W-1:0]     o_event_code
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_char) && $stable(o_event_code)
            && $stable(o_head_length) && $stable(o_lines_waiting))
        else $error("stalled result changed");

    // Accepting an item raises o_stall, so the core holds one item at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken on back-to-back cycles");

    // An empty queue reports no head line
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QUEUE_DEPTH < 8) && o_valid && (o_lines_waiting == '0) |-> (o_head_length == '0))
        else $error("head length with empty queue");

    // After a commit there is a non-empty head line
    a_queued_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LINE_LEN <= 128) && o_valid && (o_event_code == slaq_pkg::EV_QUEUED)
            |-> (o_head_length != '0) && (o_lines_waiting != '0))
        else $error("queued line not visible");

    // Only a read returns a character, and a read raises no event
    a_char_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_read_char != '0) |-> (o_event_code == slaq_pkg::EV_NONE))
        else $error("character returned with an event");

endmodule

bind serial_line_assembler_queue_core slaq_checker #(
    .LINE_LEN    (LINE_LEN),
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_slaq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_read_char     (o_read_char),
    .o_head_length   (o_head_length),
    .o_lines_waiting (o_lines_waiting),
    .o_event_code    (o_event_code)
);
